/* hdl/sdte_pkg.sv */
// Shared constants, types and helpers for the signed decimal text emitter.
// Used by sdte_dabble and signed_decimal_text_emitter_core; no dependencies.
package sdte_pkg;

  // Width of the input port and width of the converted value
  localparam int VALUE_PORT_W = 64;
  localparam int VALUE_WIDTH  = 64;

  // Decimal digits needed for the largest magnitude 2^(VALUE_WIDTH-1):
  // floor((W-1) * log10(2)) + 1
  localparam int DIGIT_DEPTH = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int DIG_IDX_W   = $clog2(DIGIT_DEPTH);

  // Converter consumes two magnitude bits per cycle
  localparam int STEPS  = (VALUE_WIDTH + 1) / 2;
  localparam int SH_W   = 2 * STEPS;
  localparam int STEP_W = $clog2(STEPS + 1);

  // Character codes
  localparam logic [6:0] CODE_ZERO  = 7'd48;
  localparam logic [6:0] CODE_MINUS = 7'd45;

  // Add-3 correction for shift-and-add BCD conversion
  localparam logic [3:0] DAB_LIMIT = 4'd5;
  localparam logic [3:0] DAB_ADJ   = 4'd3;

  typedef logic [DIGIT_DEPTH-1:0][3:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Converter status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  // One shift-and-add-3 step: correct each digit, then shift one bit in
  function automatic bcd_t dabble_bit(bcd_t b, logic din);
    bcd_t adj;
    bcd_t res;
    for (int i = 0; i < DIGIT_DEPTH; i++) begin
      adj[i] = (b[i] >= DAB_LIMIT) ? b[i] + DAB_ADJ : b[i];
    end
    res[0] = {adj[0][2:0], din};
    for (int i = 1; i < DIGIT_DEPTH; i++) begin
      res[i] = {adj[i][2:0], adj[i-1][3]};
    end
    return res;
  endfunction

endpackage

/* hdl/sdte_dabble.sv */
// Iterative binary-to-BCD converter: shift-and-add-3, two bits per cycle.
// Depends on sdte_pkg.
module sdte_dabble
  import sdte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] mag,
  output dab_stat_t              stat,
  output bcd_t                   bcd
);

  logic [SH_W-1:0]   sh;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  bcd_t              bcd_half;
  bcd_t              bcd_next;

  // Two dependent conversion steps per cycle
  always_comb begin
    bcd_half = dabble_bit(bcd, sh[SH_W-1]);
    bcd_next = dabble_bit(bcd_half, sh[SH_W-2]);
  end

  // Sequencing: step counter and status flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Done pulses once, the cycle after the final step
      done <= busy && !start && (cnt == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: magnitude shifter and digit register
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= SH_W'(mag);
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[SH_W-3:0], 2'b00};
      bcd <= bcd_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* hdl/signed_decimal_text_emitter_core.sv */
// Top level: signed integer in, decimal ASCII text out, one character per output transfer.
// Depends on sdte_pkg and sdte_dabble.
//
//   channel | signals                        | direction | payload
//   --------+--------------------------------+-----------+----------------------
//   input   | in_valid, in_stall, value      | in        | 64-bit signed value
//   output  | out_valid, out_stall,          | out       | ASCII char + last flag
//           | char_code, last_char           |           |
//
// An input request is accepted, passes through the two-bit-per-cycle BCD converter,
// has its leading digit found, then gives its characters (1 to 20), one character per
// cycle while out_stall is low.
// in_stall stays high from acceptance until the last character is registered.
// out_stall, while out_valid is high, holds the output register and pauses the character sequencer.
// rst is synchronous and clears the sequencer and the output valid flag.
module signed_decimal_text_emitter_core
  import sdte_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [VALUE_PORT_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [6:0]              char_code,
  output logic                    last_char
);

  state_t                 state;
  state_t                 state_next;
  logic                   neg;
  logic [DIG_IDX_W-1:0]   idx;
  logic [DIG_IDX_W-1:0]   idx_next;
  logic [DIG_IDX_W-1:0]   top_idx;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   accept;
  logic                   load_ok;
  logic                   load_sign;
  logic                   load_digit;
  logic [6:0]             char_code_next;
  logic                   last_char_next;
  dab_stat_t              dstat;
  bcd_t                   bcd;

  // Input side: magnitude through an unsigned negate
  assign accept = in_valid && !in_stall;
  assign v      = value[VALUE_WIDTH-1:0];
  assign mag    = v[VALUE_WIDTH-1] ? VALUE_WIDTH'(~v + 1'b1) : v;

  sdte_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .stat  (dstat),
    .bcd   (bcd)
  );

  // Leading nonzero digit; zero value leaves index 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGIT_DEPTH; i++) begin
      if (bcd[i] != 4'd0) top_idx = DIG_IDX_W'(i);
    end
  end

  // Output register can take a character when empty or being drained
  assign load_ok = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_CONV;
      ST_CONV: if (dstat.done) state_next = neg ? ST_SIGN : ST_EMIT;
      ST_SIGN: if (load_ok) state_next = ST_EMIT;
      ST_EMIT: if (load_ok && idx == '0) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall       = 1'b1;
    load_sign      = 1'b0;
    load_digit     = 1'b0;
    idx_next       = idx;
    char_code_next = CODE_ZERO + {3'b000, bcd[idx]};
    last_char_next = (idx == '0);
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_CONV: if (dstat.done) idx_next = top_idx;
      ST_SIGN: begin
        load_sign      = load_ok;
        char_code_next = CODE_MINUS;
        last_char_next = 1'b0;
      end
      ST_EMIT: begin
        load_digit = load_ok;
        if (load_ok && idx != '0) idx_next = idx - 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_sign || load_digit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) neg <= v[VALUE_WIDTH-1];
    if (load_sign || load_digit) begin
      char_code <= char_code_next;
      last_char <= last_char_next;
    end
  end

  // Block only takes a request when the converter is free
  assert property (@(posedge clk) disable iff (rst) !in_stall |-> !dstat.busy)
    else $error("request taken while converter busy");

  // Converter finishes only after a busy period
  assert property (@(posedge clk) disable iff (rst) dstat.done |-> $past(dstat.busy))
    else $error("converter done without busy");

  // Every non-sign character is a decimal digit
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && char_code != CODE_MINUS) |-> (char_code >= CODE_ZERO &&
                                                  char_code <= CODE_ZERO + 7'd9))
    else $error("character is not a decimal digit");

  // A minus sign is never the final character
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && char_code == CODE_MINUS) |-> !last_char)
    else $error("minus sign flagged as last");

endmodule
